// ===== hdl/i2cmb_pkg.sv =====
// Package for the I2C master byte engine: phase and command codes,
// configuration and result structures, and register reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cmb_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_STA_A = 4'd1,
      PH_STA_B = 4'd2,
      PH_STO_A = 4'd3,
      PH_STO_B = 4'd4,
      PH_STO_C = 4'd5,
      PH_WR_LO = 4'd6,
      PH_WR_HI = 4'd7,
      PH_AK_LO = 4'd8,
      PH_AK_HI = 4'd9,
      PH_RD_LO = 4'd10,
      PH_RD_HI = 4'd11,
      PH_RA_LO = 4'd12,
      PH_RA_HI = 4'd13
   } phase_type;

   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [1:0] CSR_SETUP_HOLD  = 2'd0;
   localparam logic [1:0] CSR_HALF_BIT    = 2'd1;
   localparam logic [1:0] CSR_READ_HIGH   = 2'd2;
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd3;

   localparam logic [7:0] SETUP_HOLD_RESET  = 8'd4;
   localparam logic [7:0] HALF_BIT_RESET    = 8'd2;
   localparam logic [7:0] READ_HIGH_RESET   = 8'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [7:0] setup_hold_ticks;
      logic [7:0] half_bit_ticks;
      logic [7:0] read_high_ticks;
      logic [7:0] ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/i2cmb_csr.sv =====
// Timing configuration registers of the I2C master byte engine.
// Depends on i2cmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_csr
   import i2cmb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output cfg_type         cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_hold_ticks  <= SETUP_HOLD_RESET;
         cfg_ff.half_bit_ticks    <= HALF_BIT_RESET;
         cfg_ff.read_high_ticks   <= READ_HIGH_RESET;
         cfg_ff.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SETUP_HOLD:  cfg_ff.setup_hold_ticks  <= csr_wdata;
            CSR_HALF_BIT:    cfg_ff.half_bit_ticks    <= csr_wdata;
            CSR_READ_HIGH:   cfg_ff.read_high_ticks   <= csr_wdata;
            CSR_ACK_TIMEOUT: cfg_ff.ack_timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/i2cmb_core.sv =====
// Bus phase sequencer of the I2C master byte engine: one tick per accepted word,
// producing the line levels and status after that tick. Depends on i2cmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_core
   import i2cmb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire logic [2:0] operation,
   input  wire logic [7:0] tx_byte,
   input  wire logic       send_ack,
   input  wire logic       sda_in,
   input  wire cfg_type    cfg,
   output rsp_type         result
);

   phase_type  phase_ff, phase_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_reg_ff, shift_reg_in;
   logic [7:0] wait_count_ff, wait_count_in;
   logic       ack_choice_ff, ack_choice_in;
   logic       scl_level_ff, scl_level_in;
   logic       sda_level_ff, sda_level_in;
   logic       nack_flag_ff, nack_flag_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic       go;
   phase_type  go_phase;
   logic       done;
   logic [7:0] tick_inc;
   logic       released;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_count_ff  <= '0;
         shift_reg_ff  <= '0;
         wait_count_ff <= '0;
         ack_choice_ff <= 1'b0;
         scl_level_ff  <= 1'b1;
         sda_level_ff  <= 1'b1;
         nack_flag_ff  <= 1'b0;
         rx_hold_ff    <= '0;
      end else if (tick) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_count_ff  <= bit_count_in;
         shift_reg_ff  <= shift_reg_in;
         wait_count_ff <= wait_count_in;
         ack_choice_ff <= ack_choice_in;
         scl_level_ff  <= scl_level_in;
         sda_level_ff  <= sda_level_in;
         nack_flag_ff  <= nack_flag_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

   assign tick_inc = tick_count_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bit_count_in  = bit_count_ff;
      shift_reg_in  = shift_reg_ff;
      wait_count_in = wait_count_ff;
      ack_choice_in = ack_choice_ff;
      scl_level_in  = scl_level_ff;
      sda_level_in  = sda_level_ff;
      nack_flag_in  = nack_flag_ff;
      rx_hold_in    = rx_hold_ff;
      go            = 1'b0;
      go_phase      = PH_IDLE;
      done          = 1'b0;

      if (phase_ff == PH_IDLE) begin
         case (operation)
            OP_START: begin
               go = 1'b1;
               go_phase = PH_STA_A;
            end
            OP_STOP: begin
               go = 1'b1;
               go_phase = PH_STO_A;
            end
            OP_WRITE: begin
               shift_reg_in = tx_byte;
               bit_count_in = '0;
               nack_flag_in = 1'b0;
               go = 1'b1;
               go_phase = PH_WR_LO;
            end
            OP_READ: begin
               shift_reg_in  = '0;
               bit_count_in  = '0;
               ack_choice_in = send_ack;
               go = 1'b1;
               go_phase = PH_RD_LO;
            end
            default: ;
         endcase
      end else begin
         // The ack wait counts in its own counter, so the tick count holds there.
         if (phase_ff != PH_AK_HI) begin
            tick_count_in = tick_inc;
         end
         case (phase_ff)
            PH_STA_A: begin
               if (tick_inc >= cfg.setup_hold_ticks) begin
                  go = 1'b1;
                  go_phase = PH_STA_B;
               end
            end
            PH_STA_B: begin
               if (tick_inc >= cfg.setup_hold_ticks) begin
                  scl_level_in = 1'b0;
                  done = 1'b1;
               end
            end
            PH_STO_A: begin
               if (tick_inc >= cfg.setup_hold_ticks) begin
                  go = 1'b1;
                  go_phase = PH_STO_B;
               end
            end
            PH_STO_B: begin
               if (tick_inc >= cfg.setup_hold_ticks) begin
                  go = 1'b1;
                  go_phase = PH_STO_C;
               end
            end
            PH_STO_C: begin
               if (tick_inc >= cfg.setup_hold_ticks) begin
                  done = 1'b1;
               end
            end
            PH_WR_LO: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  go = 1'b1;
                  go_phase = PH_WR_HI;
               end
            end
            PH_WR_HI: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  shift_reg_in = {shift_reg_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  go = 1'b1;
                  go_phase = (bit_count_in >= BITS_PER_BYTE) ? PH_AK_LO : PH_WR_LO;
               end
            end
            PH_AK_LO: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  go = 1'b1;
                  go_phase = PH_AK_HI;
               end
            end
            PH_AK_HI: begin
               if (!sda_in) begin
                  scl_level_in = 1'b0;
                  done = 1'b1;
               end else if (wait_count_ff >= cfg.ack_timeout_ticks) begin
                  nack_flag_in = 1'b1;
                  go = 1'b1;
                  go_phase = PH_STO_A;
               end else begin
                  wait_count_in = wait_count_ff + 8'd1;
               end
            end
            PH_RD_LO: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  go = 1'b1;
                  go_phase = PH_RD_HI;
               end
            end
            PH_RD_HI: begin
               // The bit is sampled on the first tick after SCL rose.
               if (tick_inc == 8'd1) begin
                  shift_reg_in = {shift_reg_ff[6:0], sda_in};
               end
               if (tick_inc >= cfg.read_high_ticks) begin
                  bit_count_in = bit_count_ff + 4'd1;
                  go = 1'b1;
                  go_phase = (bit_count_in >= BITS_PER_BYTE) ? PH_RA_LO : PH_RD_LO;
               end
            end
            PH_RA_LO: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  go = 1'b1;
                  go_phase = PH_RA_HI;
               end
            end
            PH_RA_HI: begin
               if (tick_inc >= cfg.half_bit_ticks) begin
                  scl_level_in = 1'b0;
                  rx_hold_in = shift_reg_ff;
                  done = 1'b1;
               end
            end
            default: ;
         endcase
         if (done) begin
            phase_in = PH_IDLE;
            tick_count_in = '0;
         end
      end

      // Entering a phase restarts its tick count and sets its line levels.
      if (go) begin
         phase_in = go_phase;
         tick_count_in = '0;
         case (go_phase)
            PH_STA_A: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            PH_STA_B: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b0;
            end
            PH_STO_A: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b0;
            end
            PH_STO_B: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b0;
            end
            PH_STO_C: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            PH_WR_LO: begin
               scl_level_in = 1'b0;
               sda_level_in = shift_reg_in[7];
            end
            PH_WR_HI: begin
               scl_level_in = 1'b1;
            end
            PH_AK_LO: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b1;
            end
            PH_AK_HI: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
               wait_count_in = '0;
            end
            PH_RD_LO: begin
               scl_level_in = 1'b0;
               sda_level_in = 1'b1;
            end
            PH_RD_HI: begin
               scl_level_in = 1'b1;
               sda_level_in = 1'b1;
            end
            PH_RA_LO: begin
               scl_level_in = 1'b0;
               sda_level_in = ~ack_choice_in;
            end
            PH_RA_HI: begin
               scl_level_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign released = (phase_in == PH_AK_LO) || (phase_in == PH_AK_HI) ||
                     (phase_in == PH_RD_LO) || (phase_in == PH_RD_HI);

   always_comb begin
      result.scl       = scl_level_in;
      result.sda_out   = released ? 1'b1 : sda_level_in;
      result.sda_drive = ~released;
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.rx_byte   = rx_hold_in;
      result.nack      = nack_flag_in;
   end

endmodule

`default_nettype wire

// ===== hdl/i2cmb_out_reg.sv =====
// Result register of the I2C master byte engine; holds one word until taken.
// Depends on i2cmb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmb_out_reg
   import i2cmb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   input  wire logic    rsp_stall,
   output wire logic    rsp_valid,
   output wire logic    can_load,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   // A new word may enter when the slot is empty or is being drained this cycle.
   assign can_load = ~valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_byte_engine_top.sv =====
// I2C master byte engine, top level. Each accepted word is one bus tick.
// The result word of a tick is registered: it appears in the cycle after the
// tick is accepted. One word per cycle while the result side does not stall;
// the phase sequencer updates its state once per tick and the result register
// decouples the two channels. Reset (synchronous, active high): bus idle with
// SCL and SDA high, timing registers at their defaults, no result word pending.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine_top
   import i2cmb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output wire logic       req_stall,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_send_ack,
   input  wire logic       req_sda_in,
   output wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   output wire logic       rsp_scl,
   output wire logic       rsp_sda_out,
   output wire logic       rsp_sda_drive,
   output wire logic       rsp_busy_res,
   output wire logic       rsp_done_res,
   output wire logic [7:0] rsp_rx_byte,
   output wire logic       rsp_nack,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   cfg_type cfg;
   rsp_type core_result;
   rsp_type rsp_data;
   logic    can_load;
   logic    fire;

   assign req_stall = ~can_load;
   assign fire      = req_valid & can_load;

   i2cmb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cmb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .tick      (fire),
      .operation (req_operation),
      .tx_byte   (req_tx_byte),
      .send_ack  (req_send_ack),
      .sda_in    (req_sda_in),
      .cfg       (cfg),
      .result    (core_result)
   );

   i2cmb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_data (core_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_data  (rsp_data)
   );

   assign rsp_scl       = rsp_data.scl;
   assign rsp_sda_out   = rsp_data.sda_out;
   assign rsp_sda_drive = rsp_data.sda_drive;
   assign rsp_busy_res  = rsp_data.busy_res;
   assign rsp_done_res  = rsp_data.done_res;
   assign rsp_rx_byte   = rsp_data.rx_byte;
   assign rsp_nack      = rsp_data.nack;

endmodule

`default_nettype wire

// ===== dv/i2cmb_bus_checker.sv =====
// Checker for the I2C master byte engine: watches the tick, result and
// register ports, predicts every result word and compares it field by field.
// Depends on i2cmb_pkg for the phase, command and register codes.
`timescale 1ns / 1ps

module i2cmb_bus_checker
   import i2cmb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_scl,
   input  logic       rsp_sda_out,
   input  logic       rsp_sda_drive,
   input  logic       rsp_busy_res,
   input  logic       rsp_done_res,
   input  logic [7:0] rsp_rx_byte,
   input  logic       rsp_nack,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_words,
   output int         bus_done_count,
   output int         ack_timeout_count
);

   cfg_type    timing;
   phase_type  ph;
   logic [7:0] tick_cnt;
   logic [3:0] bit_cnt;
   logic [7:0] shifter;
   logic [7:0] wait_cnt;
   logic       ack_sel;
   logic       scl_q;
   logic       sda_q;
   logic       nack_q;
   logic [7:0] rx_hold;

   rsp_type    predicted_words[$];
   int         fail_tally;
   int         done_tally;
   int         timeout_tally;

   // Entering a phase restarts its tick count and sets the line levels it drives.
   task automatic enter_bus_phase(input phase_type p);
      ph = p;
      tick_cnt = 8'd0;
      case (p)
         PH_STA_A: begin scl_q = 1'b1; sda_q = 1'b1; end
         PH_STA_B: begin scl_q = 1'b1; sda_q = 1'b0; end
         PH_STO_A: begin scl_q = 1'b0; sda_q = 1'b0; end
         PH_STO_B: begin scl_q = 1'b1; sda_q = 1'b0; end
         PH_STO_C: begin scl_q = 1'b1; sda_q = 1'b1; end
         PH_WR_LO: begin scl_q = 1'b0; sda_q = shifter[7]; end
         PH_WR_HI: scl_q = 1'b1;
         PH_AK_LO, PH_RD_LO: begin scl_q = 1'b0; sda_q = 1'b1; end
         PH_AK_HI: begin scl_q = 1'b1; sda_q = 1'b1; wait_cnt = 8'd0; end
         PH_RD_HI: begin scl_q = 1'b1; sda_q = 1'b1; end
         PH_RA_LO: begin scl_q = 1'b0; sda_q = ~ack_sel; end
         PH_RA_HI: scl_q = 1'b1;
         default: ;
      endcase
   endtask

   task automatic advance_bus_tick(input logic [2:0] op, input logic [7:0] tx,
                                   input logic ack, input logic sda,
                                   output rsp_type w);
      logic fin;
      logic released;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
         case (op)
            OP_START: enter_bus_phase(PH_STA_A);
            OP_STOP:  enter_bus_phase(PH_STO_A);
            OP_WRITE: begin
               shifter = tx;
               bit_cnt = 4'd0;
               nack_q = 1'b0;
               enter_bus_phase(PH_WR_LO);
            end
            OP_READ: begin
               shifter = 8'd0;
               bit_cnt = 4'd0;
               ack_sel = ack;
               enter_bus_phase(PH_RD_LO);
            end
            default: ;
         endcase
      end else begin
         // The ack wait counts SDA-high ticks instead of phase ticks.
         if (ph != PH_AK_HI) tick_cnt = tick_cnt + 8'd1;
         case (ph)
            PH_STA_A: if (tick_cnt >= timing.setup_hold_ticks) enter_bus_phase(PH_STA_B);
            PH_STA_B: if (tick_cnt >= timing.setup_hold_ticks) begin
               scl_q = 1'b0;
               fin = 1'b1;
            end
            PH_STO_A: if (tick_cnt >= timing.setup_hold_ticks) enter_bus_phase(PH_STO_B);
            PH_STO_B: if (tick_cnt >= timing.setup_hold_ticks) enter_bus_phase(PH_STO_C);
            PH_STO_C: if (tick_cnt >= timing.setup_hold_ticks) fin = 1'b1;
            PH_WR_LO: if (tick_cnt >= timing.half_bit_ticks) enter_bus_phase(PH_WR_HI);
            PH_WR_HI: if (tick_cnt >= timing.half_bit_ticks) begin
               shifter = {shifter[6:0], 1'b0};
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= BITS_PER_BYTE) enter_bus_phase(PH_AK_LO);
               else enter_bus_phase(PH_WR_LO);
            end
            PH_AK_LO: if (tick_cnt >= timing.half_bit_ticks) enter_bus_phase(PH_AK_HI);
            PH_AK_HI: begin
               if (!sda) begin
                  scl_q = 1'b0;
                  fin = 1'b1;
               end else if (wait_cnt >= timing.ack_timeout_ticks) begin
                  nack_q = 1'b1;
                  enter_bus_phase(PH_STO_A);
               end else begin
                  wait_cnt = wait_cnt + 8'd1;
               end
            end
            PH_RD_LO: if (tick_cnt >= timing.half_bit_ticks) enter_bus_phase(PH_RD_HI);
            PH_RD_HI: begin
               // The bit is sampled on the first tick after SCL rose.
               if (tick_cnt == 8'd1) shifter = {shifter[6:0], sda};
               if (tick_cnt >= timing.read_high_ticks) begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= BITS_PER_BYTE) enter_bus_phase(PH_RA_LO);
                  else enter_bus_phase(PH_RD_LO);
               end
            end
            PH_RA_LO: if (tick_cnt >= timing.half_bit_ticks) enter_bus_phase(PH_RA_HI);
            PH_RA_HI: if (tick_cnt >= timing.half_bit_ticks) begin
               scl_q = 1'b0;
               rx_hold = shifter;
               fin = 1'b1;
            end
            default: ;
         endcase
         if (fin) begin
            ph = PH_IDLE;
            tick_cnt = 8'd0;
         end
      end
      released = (ph == PH_AK_LO || ph == PH_AK_HI || ph == PH_RD_LO || ph == PH_RD_HI);
      w.scl = scl_q;
      w.sda_out = released ? 1'b1 : sda_q;
      w.sda_drive = ~released;
      w.busy_res = (ph != PH_IDLE);
      w.done_res = fin;
      w.rx_byte = rx_hold;
      w.nack = nack_q;
   endtask

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%02h, got 0x%02h", field, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin : track
      rsp_type want_w;
      rsp_type got_w;
      logic    nack_before;
      if (reset) begin
         timing = '{SETUP_HOLD_RESET, HALF_BIT_RESET, READ_HIGH_RESET, ACK_TIMEOUT_RESET};
         ph = PH_IDLE;
         tick_cnt = 8'd0;
         bit_cnt = 4'd0;
         shifter = 8'd0;
         wait_cnt = 8'd0;
         ack_sel = 1'b0;
         scl_q = 1'b1;
         sda_q = 1'b1;
         nack_q = 1'b0;
         rx_hold = 8'd0;
         predicted_words.delete();
         fail_tally = 0;
         done_tally = 0;
         timeout_tally = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SETUP_HOLD:  timing.setup_hold_ticks = csr_wdata;
               CSR_HALF_BIT:    timing.half_bit_ticks = csr_wdata;
               CSR_READ_HIGH:   timing.read_high_ticks = csr_wdata;
               CSR_ACK_TIMEOUT: timing.ack_timeout_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               $error("result word arrived with no prediction pending");
               fail_tally++;
            end else begin
               want_w = predicted_words.pop_front();
               got_w = {rsp_scl, rsp_sda_out, rsp_sda_drive, rsp_busy_res,
                        rsp_done_res, rsp_rx_byte, rsp_nack};
               compare_field("scl", want_w.scl, got_w.scl);
               compare_field("sda_out", want_w.sda_out, got_w.sda_out);
               compare_field("sda_drive", want_w.sda_drive, got_w.sda_drive);
               compare_field("busy_res", want_w.busy_res, got_w.busy_res);
               compare_field("done_res", want_w.done_res, got_w.done_res);
               compare_field("rx_byte", want_w.rx_byte, got_w.rx_byte);
               compare_field("nack", want_w.nack, got_w.nack);
            end
         end
         if (req_valid && !req_stall) begin
            nack_before = nack_q;
            advance_bus_tick(req_operation, req_tx_byte, req_send_ack, req_sda_in, want_w);
            predicted_words.push_back(want_w);
            if (want_w.done_res) done_tally++;
            if (want_w.nack && !nack_before) timeout_tally++;
         end
      end
      mismatch_count <= fail_tally;
      pending_words <= predicted_words.size();
      bus_done_count <= done_tally;
      ack_timeout_count <= timeout_tally;
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the I2C master byte engine: clock, reset, bus tick
// stimulus, register programming, result back-pressure and the verdict.
// Depends on i2cmb_pkg, i2c_master_byte_engine_top and i2cmb_bus_checker.
`timescale 1ns / 1ps

module tb_top;
   import i2cmb_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_SHORT, STALL_LONG} stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_operation = OP_NONE;
   logic [7:0] req_tx_byte = 8'd0;
   logic       req_send_ack = 1'b0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl;
   logic       rsp_sda_out;
   logic       rsp_sda_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_nack;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = CSR_SETUP_HOLD;
   logic [7:0] csr_wdata = 8'd0;

   int mismatch_count;
   int pending_words;
   int bus_done_count;
   int ack_timeout_count;

   int burst_left = 0;
   int engine_ticks = 0;
   int random_ticks = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;
   int stall_step = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   i2c_master_byte_engine_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_tx_byte(req_tx_byte),
      .req_send_ack(req_send_ack), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scl(rsp_scl), .rsp_sda_out(rsp_sda_out), .rsp_sda_drive(rsp_sda_drive),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_rx_byte(rsp_rx_byte), .rsp_nack(rsp_nack),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   i2cmb_bus_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_tx_byte(req_tx_byte),
      .req_send_ack(req_send_ack), .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scl(rsp_scl), .rsp_sda_out(rsp_sda_out), .rsp_sda_drive(rsp_sda_drive),
      .rsp_busy_res(rsp_busy_res), .rsp_done_res(rsp_done_res),
      .rsp_rx_byte(rsp_rx_byte), .rsp_nack(rsp_nack),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_words(pending_words),
      .bus_done_count(bus_done_count), .ack_timeout_count(ack_timeout_count)
   );

   // The result side cycles through stall patterns, including stretches without any.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(60, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      stall_step <= stall_step + 1;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_SHORT:  rsp_stall <= (stall_step % 5) >= 3;
         default:      rsp_stall <= (stall_step % 16) < 9;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic line_sample(input int low_pct);
      return $urandom_range(0, 99) >= low_pct;
   endfunction

   // Sends one tick word, opening a random gap first whenever a burst has run out.
   task automatic put_tick(input logic [2:0] op, input logic [7:0] tx,
                           input logic ack, input logic sda);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_tx_byte <= tx;
      req_send_ack <= ack;
      req_sda_in <= sda;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic write_regs(input cfg_type c, input logic [3:0] mask);
      logic [1:0] idx [4];
      logic [7:0] val [4];
      idx = '{CSR_SETUP_HOLD, CSR_HALF_BIT, CSR_READ_HIGH, CSR_ACK_TIMEOUT};
      val = '{c.setup_hold_ticks, c.half_bit_ticks, c.read_high_ticks, c.ack_timeout_ticks};
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            csr_wr_en <= 1'b1;
            csr_index <= idx[i];
            csr_wdata <= val[i];
            @(posedge clock);
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic retime(input cfg_type c);
      drain();
      write_regs(c, 4'hF);
      settings_used++;
   endtask

   // Ticks until the command in flight finishes. Early ticks, while the engine is
   // surely still busy, may carry stray commands that it must ignore.
   task automatic finish_command(input int base, input int guard, input int low_pct);
      int k;
      k = 0;
      while (bus_done_count == base) begin
         if (k < guard && $urandom_range(0, 3) == 0)
            put_tick($urandom_range(OP_START, OP_READ + 3), $urandom, $urandom,
                     line_sample(low_pct));
         else
            put_tick(OP_NONE, $urandom, $urandom, line_sample(low_pct));
         engine_ticks++;
         k++;
      end
   endtask

   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic ack, input int low_pct);
      int base;
      int guard;
      base = bus_done_count;
      guard = (op == OP_START) ? 1 : (op == OP_STOP) ? 2 : 10;
      put_tick(op, tx, ack, line_sample(low_pct));
      engine_ticks++;
      finish_command(base, guard, low_pct);
   endtask

   function automatic int ack_low_pct();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 0;
      if (pick < 4) return 15;
      if (pick < 7) return 60;
      return 100;
   endfunction

   // Mostly well-formed transfers; now and then a broken sequence or idle noise.
   task automatic random_transaction();
      int n;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: run_command(OP_STOP, $urandom, $urandom, 50);
            1: run_command(OP_WRITE, $urandom, $urandom, ack_low_pct());
            2: run_command(OP_READ, $urandom, $urandom, $urandom_range(0, 100));
            default: begin
               repeat ($urandom_range(1, 6))
                  put_tick($urandom_range(0, 1) ? OP_NONE : OP_READ + $urandom_range(1, 3),
                           $urandom, $urandom, $urandom);
            end
         endcase
      end else begin
         run_command(OP_START, $urandom, $urandom, 50);
         n = $urandom_range(1, 4);
         repeat (n) begin
            if ($urandom_range(0, 1))
               run_command(OP_WRITE, $urandom, $urandom, ack_low_pct());
            else
               run_command(OP_READ, $urandom, $urandom, $urandom_range(0, 100));
         end
         // Leaving out the stop makes the next start a repeated start.
         if ($urandom_range(0, 3) != 0) run_command(OP_STOP, $urandom, $urandom, 50);
      end
   endtask

   task automatic run_random(input int span);
      int start;
      start = engine_ticks;
      do random_transaction(); while (engine_ticks - start < span);
      random_ticks += engine_ticks - start;
   endtask

   initial begin : stimulus
      cfg_type c;
      int base;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset timing: unused operation codes while idle, then each command.
      put_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
      for (int i = 1; i <= 3; i++) put_tick(OP_READ + i, 8'hFF, 1'b1, 1'b1);
      run_command(OP_START, 8'h00, 1'b0, 50);
      run_command(OP_WRITE, 8'hFF, 1'b0, 30);
      run_command(OP_WRITE, 8'h00, 1'b1, 0);
      run_command(OP_READ, 8'h00, 1'b1, 50);
      run_command(OP_READ, 8'hFF, 1'b0, 0);
      run_command(OP_READ, 8'h00, 1'b1, 100);
      run_command(OP_START, 8'h00, 1'b0, 50);
      run_command(OP_WRITE, 8'hA5, 1'b0, 100);
      run_command(OP_STOP, 8'h00, 1'b0, 50);
      run_command(OP_STOP, 8'h00, 1'b0, 50);

      // Retime in the middle of a byte; a zero ack timeout then fails at once.
      c = '{SETUP_HOLD_RESET, HALF_BIT_RESET, READ_HIGH_RESET, ACK_TIMEOUT_RESET};
      base = bus_done_count;
      put_tick(OP_WRITE, 8'h3C, 1'b0, 1'b1);
      repeat (5) put_tick(OP_NONE, 8'h00, 1'b0, 1'b1);
      engine_ticks += 6;
      drain();
      c.half_bit_ticks = 8'd3;
      c.ack_timeout_ticks = 8'd0;
      write_regs(c, 4'b1010);
      finish_command(base, 0, 0);

      c = '{8'd0, 8'd0, 8'd0, 8'd0};
      retime(c);
      run_random(200);
      c = '{8'd1, 8'd1, 8'd1, 8'd1};
      retime(c);
      run_random(200);

      // Slowest timing: one start runs both of its phases to the full count.
      c = '{8'd255, 8'd255, 8'd255, 8'd255};
      retime(c);
      run_command(OP_START, $urandom, $urandom, 50);

      while (random_ticks < 550) begin
         c.setup_hold_ticks = $urandom_range(0, 4);
         c.half_bit_ticks = $urandom_range(0, 4);
         c.read_high_ticks = $urandom_range(0, 4);
         c.ack_timeout_ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 255)
                                                            : $urandom_range(0, 6);
         retime(c);
         run_random($urandom_range(150, 300));
      end
      c = '{SETUP_HOLD_RESET, HALF_BIT_RESET, READ_HIGH_RESET, ACK_TIMEOUT_RESET};
      retime(c);
      run_random(150);

      drain();
      repeat (4) @(posedge clock);
      $display("Run covered %0d engine ticks under %0d timing settings.",
               engine_ticks, settings_used);
      $display("%0d commands completed, %0d write acknowledgements timed out.",
               bus_done_count, ack_timeout_count);
      if (mismatch_count == 0 && pending_words == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
